// ----- rtl/core/stid_pkg.sv -----
// ----------------------------------------------------------------------------
// stid_pkg: shared types and constants for the sorted table
// Word layouts, opcodes, status codes and cell control.
// ----------------------------------------------------------------------------
`default_nettype none

package stid_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;
  localparam int POS_W = 4;
  localparam int RIX_W = 4;

  localparam logic [OP_W-1:0] OP_INSERT = OP_W'(0);
  localparam logic [OP_W-1:0] OP_DELETE = OP_W'(1);
  localparam logic [OP_W-1:0] OP_READ   = OP_W'(2);

  localparam logic [ST_W-1:0] ST_OK        = ST_W'(0);
  localparam logic [ST_W-1:0] ST_NOT_FOUND = ST_W'(1);
  localparam logic [ST_W-1:0] ST_FULL      = ST_W'(2);
  localparam logic [ST_W-1:0] ST_BAD_INDEX = ST_W'(3);

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic signed [VAL_W-1:0] item_value;
    logic [RIX_W-1:0]        read_index;
  } in_word_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_W-1:0]        entry_count;
  } out_word_t;

  typedef struct packed {
    logic do_insert;
    logic do_delete;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/stid_cell.sv -----
// ----------------------------------------------------------------------------
// stid_cell: one entry of the sorted table
// Holds one value, compares it with the incoming value and takes its left or
// right neighbor's value when an insert or delete shifts the row.
// ----------------------------------------------------------------------------
`default_nettype none

module stid_cell (
  input  wire logic                             clk,
  input  wire stid_pkg::cell_ctl_t              ctl,
  input  wire logic signed [stid_pkg::VAL_W-1:0] item_value,
  input  wire logic                             held,
  input  wire logic                             tail,
  input  wire logic                             left_gt,
  input  wire logic signed [stid_pkg::VAL_W-1:0] left_entry,
  input  wire logic signed [stid_pkg::VAL_W-1:0] right_entry,
  output logic signed [stid_pkg::VAL_W-1:0]      entry,
  output logic                                  gt,
  output logic                                  ge,
  output logic                                  eq
);
  import stid_pkg::*;

  logic signed [VAL_W-1:0] entry_r;
  logic signed [VAL_W-1:0] entry_nxt;

  assign gt    = held && (entry_r > item_value);
  assign ge    = held && (entry_r >= item_value);
  assign eq    = held && (entry_r == item_value);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.do_insert) begin
      if (left_gt) begin
        entry_nxt = left_entry;
      end else if (gt || tail) begin
        entry_nxt = item_value;
      end
    end else if (ctl.do_delete && ge) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/sorted_table_insert_delete.sv -----
// ----------------------------------------------------------------------------
// sorted_table_insert_delete: ascending table of signed values
// Row of compare-and-shift cells with insert, delete and indexed read.
//
//   channel  direction  ports                       word
//   in       input      in_valid in_ready in_data    in_word_t
//   out      output     out_valid out_ready out_data out_word_t
//
// One word per cycle unless the output stalls: every cell compares and shifts
// in the accepting cycle, the result is registered and shows the next cycle.
// A new word is taken while the held result is being taken or the register
// is empty; a stalled result holds the input back.
// Reset empties the table (count zero); entry values are not cleared.
// No word is taken while reset is held.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_insert_delete (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire stid_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output stid_pkg::out_word_t      out_data
);
  import stid_pkg::*;

  logic signed [VAL_W-1:0] entry_q [DEPTH];
  logic [DEPTH-1:0]        gt_q;
  logic [DEPTH-1:0]        ge_q;
  logic [DEPTH-1:0]        eq_q;
  logic [DEPTH-1:0]        held_q;
  logic [DEPTH-1:0]        tail_q;
  logic [DEPTH-1:0]        ins_mark;
  logic [DEPTH-1:0]        del_mark;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  out_word_t        out_data_r;
  out_word_t        res;

  logic             accept;
  logic             full;
  logic             found;
  logic             rd_ok;
  logic [IDX_W-1:0] ins_pos;
  logic [IDX_W-1:0] del_pos;
  cell_ctl_t        ctl;

  assign in_ready  = rst_n && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign found = |eq_q;
  assign rd_ok = (CNT_W'(in_data.read_index) < count_r);

  assign ctl.do_insert = accept && (in_data.opcode == OP_INSERT) && !full;
  assign ctl.do_delete = accept && (in_data.opcode == OP_DELETE) && found;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    left_gt;
    logic signed [VAL_W-1:0] left_entry;
    logic signed [VAL_W-1:0] right_entry;

    assign held_q[i] = (CNT_W'(i) < count_r);
    assign tail_q[i] = (CNT_W'(i) == count_r);

    if (i == 0) begin : g_first
      assign left_gt     = 1'b0;
      assign left_entry  = '0;
      assign del_mark[i] = ge_q[i];
    end else begin : g_inner
      assign left_gt     = gt_q[i-1];
      assign left_entry  = entry_q[i-1];
      assign del_mark[i] = ge_q[i] && !ge_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_body
      assign right_entry = entry_q[i+1];
    end

    assign ins_mark[i] = (gt_q[i] || tail_q[i]) && !left_gt;

    stid_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .item_value  (in_data.item_value),
      .held        (held_q[i]),
      .tail        (tail_q[i]),
      .left_gt     (left_gt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entry_q[i]),
      .gt          (gt_q[i]),
      .ge          (ge_q[i]),
      .eq          (eq_q[i])
    );
  end

  always_comb begin
    ins_pos = '0;
    del_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (ins_mark[i]) ins_pos = ins_pos | IDX_W'(i);
      if (del_mark[i]) del_pos = del_pos | IDX_W'(i);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.do_delete) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    res.status      = ST_OK;
    res.position    = '0;
    res.read_value  = '0;
    res.entry_count = count_nxt;
    unique case (in_data.opcode)
      OP_INSERT: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          res.position = POS_W'(ins_pos);
        end
      end
      OP_DELETE: begin
        if (found) begin
          res.position = POS_W'(del_pos);
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      OP_READ: begin
        res.position = POS_W'(in_data.read_index);
        if (rd_ok) begin
          res.read_value = entry_q[IDX_W'(in_data.read_index)];
        end else begin
          res.status = ST_BAD_INDEX;
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_ins_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(ins_mark))
    else $error("insert boundary not unique");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.do_insert |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_FULL) |->
      out_data_r.entry_count == CNT_W'(DEPTH))
    else $error("full status with partial count");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_sorted_table_insert_delete.sv -----
// ----------------------------------------------------------------------------
// tb_sorted_table_insert_delete: self-checking bench for the sorted table
// Drives insert, delete and read words over valid/ready and checks every
// result word against a bench-side copy of the table.
// Directed edge cases come first, then biased random traffic that sweeps the
// fill level between empty and full. Both sides stall in random bursts, and
// a long receiver hold-off fills the block. The final stretch runs without
// any stalls.
// ----------------------------------------------------------------------------

module tb_sorted_table_insert_delete;
  import stid_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = OP_W'(3);
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 150;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  logic signed [VAL_W-1:0] table_vals [DEPTH];
  int        table_count = 0;
  out_word_t pending_results [$];
  out_word_t want_word;
  int        error_count = 0;
  int        cycle_count = 0;
  bit        tx_idle_on = 1'b1;
  bit        rx_idle_on = 1'b1;
  int        hold_req = 0;
  int        hold_left = 0;
  int        burst_left = 0;
  bit        burst_ready = 1'b1;

  sorted_table_insert_delete DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  function automatic out_word_t next_table_result(input in_word_t w);
    out_word_t r;
    logic signed [VAL_W-1:0] v;
    int i;
    v = $signed(w.item_value);
    r = '0;
    r.status = ST_OK;
    case (w.opcode)
      OP_INSERT: begin
        if (table_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          i = table_count;
          while (i > 0 && table_vals[i-1] > v) begin
            table_vals[i] = table_vals[i-1];
            i--;
          end
          table_vals[i] = v;
          table_count++;
          r.position = POS_W'(i);
        end
      end
      OP_DELETE: begin
        i = 0;
        while (i < table_count && table_vals[i] != v) i++;
        if (i >= table_count) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.position = POS_W'(i);
          for (int j = i; j + 1 < table_count; j++) table_vals[j] = table_vals[j+1];
          table_count--;
        end
      end
      OP_READ: begin
        r.position = w.read_index;
        if (int'(w.read_index) >= table_count) begin
          r.status = ST_BAD_INDEX;
        end else begin
          r.read_value = table_vals[w.read_index];
        end
      end
      default: ;
    endcase
    r.entry_count = CNT_W'(table_count);
    return r;
  endfunction

  function automatic in_word_t make_word(input logic [OP_W-1:0] op,
                                         input logic signed [VAL_W-1:0] v,
                                         input logic [RIX_W-1:0] idx);
    in_word_t w;
    w.opcode = op;
    w.item_value = v;
    w.read_index = idx;
    return w;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 4))
      1: v = $signed(VAL_W'($urandom_range(0, 16))) - 8;
      2: begin
        case ($urandom_range(0, 5))
          0: v = VAL_MIN;
          1: v = VAL_MIN + 1;
          2: v = VAL_MAX;
          3: v = VAL_MAX - 1;
          4: v = 0;
          default: v = -1;
        endcase
      end
      3, 4: if (table_count > 0) v = table_vals[$urandom_range(0, table_count - 1)];
      default: ;
    endcase
    return v;
  endfunction

  function automatic in_word_t random_word(input int insert_pct);
    in_word_t w;
    int r;
    r = $urandom_range(0, 99);
    w.item_value = pick_value();
    w.read_index = RIX_W'($urandom_range(0, 15));
    if (r < 3) w.opcode = OP_UNUSED;
    else if (r < 28) w.opcode = OP_READ;
    else if (r < 28 + insert_pct * 72 / 100) w.opcode = OP_INSERT;
    else w.opcode = OP_DELETE;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(next_table_result(w));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        burst_ready = !rx_idle_on || $urandom_range(0, 1);
      end
      burst_left--;
      out_ready <= burst_ready;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t unexpected word: expected none actual %0h", $time, out_data);
      end else begin
        want_word = pending_results.pop_front();
        check_field("status", VAL_W'(want_word.status), VAL_W'(out_data.status));
        check_field("position", VAL_W'(want_word.position), VAL_W'(out_data.position));
        check_field("read_value", want_word.read_value, out_data.read_value);
        check_field("entry_count", VAL_W'(want_word.entry_count),
                    VAL_W'(out_data.entry_count));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL sorted_table_insert_delete");
    $finish;
  end

  task automatic test_directed();
    send_word(make_word(OP_READ, 0, 0));
    send_word(make_word(OP_DELETE, 0, 0));
    send_word(make_word(OP_INSERT, VAL_MAX, 0));
    send_word(make_word(OP_INSERT, VAL_MIN, 0));
    send_word(make_word(OP_INSERT, 0, 0));
    send_word(make_word(OP_INSERT, -1, 0));
    send_word(make_word(OP_INSERT, 0, 0));
    send_word(make_word(OP_READ, 0, 0));
    send_word(make_word(OP_READ, 0, 4));
    send_word(make_word(OP_READ, 0, 5));
    send_word(make_word(OP_UNUSED, VAL_MAX, 15));
    send_word(make_word(OP_DELETE, 12345, 0));
    send_word(make_word(OP_DELETE, 0, 0));
    for (int k = 0; k < 12; k++) send_word(make_word(OP_INSERT, k * 1000 - 5000, 0));
    send_word(make_word(OP_INSERT, 7, 0));
    send_word(make_word(OP_READ, 0, 15));
    send_word(make_word(OP_DELETE, VAL_MIN, 0));
    send_word(make_word(OP_DELETE, VAL_MAX, 0));
    wait_for_results();
  endtask

  task automatic test_random_mix(input int n);
    for (int k = 0; k < n; k++) send_word(random_word(((k / 100) % 2) ? 25 : 75));
  endtask

  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    hold_req = HOLD_OFF_CYCLES;
    for (int k = 0; k < 40; k++) send_word(random_word(50));
    tx_idle_on = 1'b1;
    wait_for_results();
  endtask

  task automatic test_drain_pause();
    for (int k = 0; k < 50; k++) send_word(random_word(75));
    wait_for_results();
    for (int k = 0; k < 50; k++) send_word(random_word(25));
  endtask

  task automatic test_no_idle(input int n);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int k = 0; k < n; k++) send_word(random_word(((k / 60) % 2) ? 30 : 70));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mix(650);
    test_backpressure();
    test_drain_pause();
    test_no_idle(200);
    wait_for_results();
    if (error_count == 0) begin
      $display("PASS sorted_table_insert_delete");
    end else begin
      $display("FAIL sorted_table_insert_delete");
    end
    $finish;
  end

endmodule

// ----- sorted_table_insert_delete.f -----
rtl/core/stid_pkg.sv
rtl/core/stid_cell.sv
rtl/core/sorted_table_insert_delete.sv
sim/tb_sorted_table_insert_delete.sv
